/* rtl/core/srr_pkg.sv */
// ----------------------------------------------------------------------------
// srr_pkg
// Shared types and constants for the small region removal core.
// ----------------------------------------------------------------------------
package srr_pkg;

   typedef enum logic [3:0] {
      S_IDLE,
      S_READ,
      S_CLASS,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_GROW_RD,
      S_GROW_POP,
      S_NB_RD,
      S_NB_CHK,
      S_MARK_RD,
      S_MARK_WR,
      S_FILL
   } state_type;

   typedef enum logic {
      PH_LOADING,
      PH_READING
   } phase_type;

   typedef enum logic [1:0] {
      LBL_FREE,
      LBL_BUSY,
      LBL_REPLACE,
      LBL_KEEP
   } label_type;

   typedef enum logic [2:0] {
      REG_AREA_LIMIT,
      REG_REMOVE_WHITE,
      REG_EIGHT_CONNECTED,
      REG_IMAGE_COLS,
      REG_IMAGE_ROWS
   } reg_index_type;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [7:0]  KEEP_LEVEL     = 8'd10;
   localparam logic [7:0]  FILL_WHITE     = 8'd0;
   localparam logic [7:0]  FILL_BLACK     = 8'd255;
   localparam logic [16:0] AREA_LIMIT_RST = 17'd2000;
   localparam logic [8:0]  DIM_RST        = 9'd256;

   // neighbor offsets: left, right, up, down, then the four diagonals
   localparam logic signed [1:0] NB_DX [8] = '{
      -2'sd1, 2'sd1, 2'sd0, 2'sd0, -2'sd1, -2'sd1, 2'sd1, 2'sd1};
   localparam logic signed [1:0] NB_DY [8] = '{
      2'sd0, 2'sd0, -2'sd1, 2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd1};

endpackage

/* rtl/core/small_region_removal_core.sv */
// ----------------------------------------------------------------------------
// small_region_removal_core
// Area opening on a grey image held in on-chip memory.
// ----------------------------------------------------------------------------
// A load request (tuser 0) takes one pixel per cycle in raster order while
// the block is idle and no response is stalled. The request that completes
// the image starts processing with the registers as they stand; the block
// then takes no request through the classify and fill sweeps, the scan and,
// for every candidate pixel, region growing and marking, all paced by the
// single read port of the label memory. A read request (tuser 1) gives one
// registered result pixel from source memory; reads while loading give
// nothing, and a load during read-back drops the rest and starts anew.
module small_region_removal_core import srr_pkg::*; #(
   parameter int MAX_COLS = 256,
   parameter int MAX_ROWS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] pixel_in
   input  logic        req_tuser,   // [0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] pixel_out
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [16:0] csr_wdata
);

   localparam int DEPTH = MAX_COLS * MAX_ROWS;
   localparam int AW    = $clog2(DEPTH);
   localparam int TW    = AW + 1;
   localparam int XW    = $clog2(MAX_COLS);
   localparam int YW    = $clog2(MAX_ROWS);
   localparam int CW    = $clog2(MAX_COLS + 1);
   localparam int RW    = $clog2(MAX_ROWS + 1);
   localparam int QW    = XW + YW;

   // configuration
   logic [16:0] area_limit_ff;
   logic        remove_white_ff;
   logic        eight_ff;
   logic [8:0]  cols_ff;
   logic [8:0]  rows_ff;

   // control state
   state_type   state_ff, state_in;
   phase_type   phase_ff, phase_in;
   logic [TW-1:0] load_cnt_ff, load_cnt_in;
   logic [TW-1:0] read_cnt_ff, read_cnt_in;
   logic [TW-1:0] used_total_ff, used_total_in;
   logic [TW-1:0] total_ff, total_in;
   logic [CW-1:0] w_ff, w_in;
   logic [RW-1:0] h_ff, h_in;
   logic [TW-1:0] idx_ff, idx_in;
   logic [XW-1:0] sx_ff, sx_in;
   logic [YW-1:0] sy_ff, sy_in;
   logic [TW-1:0] head_ff, head_in;
   logic [TW-1:0] tail_ff, tail_in;
   logic [XW-1:0] cx_ff, cx_in;
   logic [YW-1:0] cy_ff, cy_in;
   logic [3:0]    nb_ff, nb_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] paddr_ff, paddr_in;
   logic [AW-1:0] naddr_ff, naddr_in;
   logic [QW-1:0] ncoord_ff, ncoord_in;
   logic          rd_last_ff, rd_last_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_pix_ff, rsp_pix_in;
   logic          rsp_last_ff, rsp_last_in;

   // memories
   logic          src_we, lbl_we, q_we;
   logic [AW-1:0] src_waddr, src_raddr, lbl_waddr, lbl_raddr, q_waddr, q_raddr;
   logic [7:0]    src_wdata, src_rdata;
   logic [1:0]    lbl_wdata, lbl_rdata;
   logic [QW-1:0] q_wdata, q_rdata;

   // address unit
   logic [XW-1:0] au_x, au_nx;
   logic [YW-1:0] au_y, au_ny;
   logic          au_center, au_valid;
   logic [AW-1:0] au_idx;

   logic [CW-1:0]    w_eff;
   logic [RW-1:0]    h_eff;
   logic [CW+RW-1:0] prod;
   logic [TW-1:0]    total_cur;
   logic             req_acc;
   logic [TW-1:0]    ld_addr, ld_next;
   logic             nb_end;
   logic             src_keep;
   logic             scan_wrap;

   srr_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_src (
      .clock(clock), .wr_en(src_we), .wr_addr(src_waddr), .wr_data(src_wdata),
      .rd_addr(src_raddr), .rd_data(src_rdata));

   srr_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_lbl (
      .clock(clock), .wr_en(lbl_we), .wr_addr(lbl_waddr), .wr_data(lbl_wdata),
      .rd_addr(lbl_raddr), .rd_data(lbl_rdata));

   srr_ram #(.WIDTH(QW), .DEPTH(DEPTH)) u_queue (
      .clock(clock), .wr_en(q_we), .wr_addr(q_waddr), .wr_data(q_wdata),
      .rd_addr(q_raddr), .rd_data(q_rdata));

   srr_addr #(.XW(XW), .YW(YW), .CW(CW), .RW(RW), .AW(AW)) u_addr (
      .x(au_x), .y(au_y), .nb(nb_ff[2:0]), .center(au_center),
      .width(w_ff), .height(h_ff), .valid(au_valid),
      .nx(au_nx), .ny(au_ny), .idx(au_idx));

   // size in use, clamped into 1..max
   always_comb begin
      if (cols_ff == 9'd0) begin
         w_eff = CW'(1);
      end else if (int'(cols_ff) > MAX_COLS) begin
         w_eff = CW'(MAX_COLS);
      end else begin
         w_eff = CW'(cols_ff);
      end
      if (rows_ff == 9'd0) begin
         h_eff = RW'(1);
      end else if (int'(rows_ff) > MAX_ROWS) begin
         h_eff = RW'(MAX_ROWS);
      end else begin
         h_eff = RW'(rows_ff);
      end
      prod = w_eff * h_eff;
      total_cur = TW'(prod);
   end

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_acc    = req_tvalid && req_tready;
   assign ld_addr    = (phase_ff == PH_READING) ? '0 : load_cnt_ff;
   assign ld_next    = ld_addr + TW'(1);
   assign nb_end     = eight_ff ? (nb_ff == 4'd8) : (nb_ff == 4'd4);
   assign src_keep   = remove_white_ff ? (src_rdata < KEEP_LEVEL)
                                       : (src_rdata > KEEP_LEVEL);
   assign scan_wrap  = (CW'(sx_ff) + CW'(1)) == w_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (req_tuser == OP_LOAD) begin
                  if (ld_next >= total_cur) begin
                     state_in = S_CLASS;
                  end
               end else if (phase_ff == PH_READING) begin
                  state_in = S_READ;
               end
            end
         end
         S_READ:     state_in = S_IDLE;
         S_CLASS:    if (idx_ff >= total_ff) state_in = S_SCAN_RD;
         S_SCAN_RD:  state_in = (idx_ff < total_ff) ? S_SCAN_CHK : S_FILL;
         S_SCAN_CHK: begin
            state_in = (label_type'(lbl_rdata) == LBL_FREE) ? S_GROW_RD : S_SCAN_RD;
         end
         S_GROW_RD:  state_in = (head_ff < tail_ff) ? S_GROW_POP : S_MARK_RD;
         S_GROW_POP: state_in = S_NB_RD;
         S_NB_RD: begin
            if (nb_end) begin
               state_in = S_GROW_RD;
            end else if (au_valid) begin
               state_in = S_NB_CHK;
            end
         end
         S_NB_CHK:   state_in = S_NB_RD;
         S_MARK_RD:  state_in = (head_ff < tail_ff) ? S_MARK_WR : S_SCAN_RD;
         S_MARK_WR:  state_in = S_MARK_RD;
         S_FILL:     if (idx_ff >= total_ff) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      phase_in      = phase_ff;
      load_cnt_in   = load_cnt_ff;
      read_cnt_in   = read_cnt_ff;
      used_total_in = used_total_ff;
      total_in      = total_ff;
      w_in          = w_ff;
      h_in          = h_ff;
      idx_in        = idx_ff;
      sx_in         = sx_ff;
      sy_in         = sy_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      nb_in         = nb_ff;
      pend_in       = pend_ff;
      paddr_in      = paddr_ff;
      naddr_in      = naddr_ff;
      ncoord_in     = ncoord_ff;
      rd_last_in    = rd_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_pix_in    = rsp_pix_ff;
      rsp_last_in   = rsp_last_ff;
      src_we    = 1'b0;
      src_waddr = ld_addr[AW-1:0];
      src_wdata = req_tdata;
      src_raddr = read_cnt_ff[AW-1:0];
      lbl_we    = 1'b0;
      lbl_waddr = paddr_ff;
      lbl_wdata = LBL_BUSY;
      lbl_raddr = idx_ff[AW-1:0];
      q_we      = 1'b0;
      q_waddr   = tail_ff[AW-1:0];
      q_wdata   = ncoord_ff;
      q_raddr   = head_ff[AW-1:0];
      au_x      = cx_ff;
      au_y      = cy_ff;
      au_center = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (req_tuser == OP_LOAD) begin
                  src_we      = 1'b1;
                  phase_in    = PH_LOADING;
                  read_cnt_in = '0;
                  if (ld_next >= total_cur) begin
                     load_cnt_in = '0;
                     total_in    = total_cur;
                     w_in        = w_eff;
                     h_in        = h_eff;
                     idx_in      = '0;
                     pend_in     = 1'b0;
                  end else begin
                     load_cnt_in = ld_next;
                  end
               end else if (phase_ff == PH_READING) begin
                  rd_last_in = (read_cnt_ff + TW'(1)) == used_total_ff;
                  if ((read_cnt_ff + TW'(1)) == used_total_ff) begin
                     read_cnt_in = '0;
                     phase_in    = PH_LOADING;
                  end else begin
                     read_cnt_in = read_cnt_ff + TW'(1);
                  end
               end
            end
         end
         S_READ: begin
            rsp_valid_in = 1'b1;
            rsp_pix_in   = src_rdata;
            rsp_last_in  = rd_last_ff;
         end
         S_CLASS: begin
            // label write comes the cycle after its source read
            src_raddr = idx_ff[AW-1:0];
            lbl_we    = pend_ff;
            lbl_wdata = src_keep ? LBL_KEEP : LBL_FREE;
            if (idx_ff < total_ff) begin
               idx_in   = idx_ff + TW'(1);
               pend_in  = 1'b1;
               paddr_in = idx_ff[AW-1:0];
            end else begin
               idx_in  = '0;
               sx_in   = '0;
               sy_in   = '0;
               pend_in = 1'b0;
            end
         end
         S_SCAN_RD: begin
            if (idx_ff >= total_ff) begin
               idx_in  = '0;
               pend_in = 1'b0;
            end
         end
         S_SCAN_CHK: begin
            if (label_type'(lbl_rdata) == LBL_FREE) begin
               q_we      = 1'b1;
               q_waddr   = '0;
               q_wdata   = {sy_ff, sx_ff};
               lbl_we    = 1'b1;
               lbl_waddr = idx_ff[AW-1:0];
               lbl_wdata = LBL_BUSY;
               head_in   = '0;
               tail_in   = TW'(1);
            end else begin
               idx_in = idx_ff + TW'(1);
               sx_in  = scan_wrap ? '0 : sx_ff + XW'(1);
               sy_in  = scan_wrap ? sy_ff + YW'(1) : sy_ff;
            end
         end
         S_GROW_RD: begin
            if (head_ff < tail_ff) begin
               head_in = head_ff + TW'(1);
            end else begin
               head_in = '0;
            end
         end
         S_GROW_POP: begin
            cy_in = q_rdata[QW-1:XW];
            cx_in = q_rdata[XW-1:0];
            nb_in = '0;
         end
         S_NB_RD: begin
            lbl_raddr = au_idx;
            naddr_in  = au_idx;
            ncoord_in = {au_ny, au_nx};
            if (!nb_end && !au_valid) begin
               nb_in = nb_ff + 4'd1;
            end
         end
         S_NB_CHK: begin
            if (label_type'(lbl_rdata) == LBL_FREE) begin
               q_we      = 1'b1;
               lbl_we    = 1'b1;
               lbl_waddr = naddr_ff;
               lbl_wdata = LBL_BUSY;
               tail_in   = tail_ff + TW'(1);
            end
            nb_in = nb_ff + 4'd1;
         end
         S_MARK_RD: begin
            if (head_ff < tail_ff) begin
               head_in = head_ff + TW'(1);
            end else begin
               idx_in = idx_ff + TW'(1);
               sx_in  = scan_wrap ? '0 : sx_ff + XW'(1);
               sy_in  = scan_wrap ? sy_ff + YW'(1) : sy_ff;
            end
         end
         S_MARK_WR: begin
            au_x      = q_rdata[XW-1:0];
            au_y      = q_rdata[QW-1:XW];
            au_center = 1'b1;
            lbl_we    = 1'b1;
            lbl_waddr = au_idx;
            lbl_wdata = (int'(tail_ff) > int'(area_limit_ff)) ? LBL_KEEP : LBL_REPLACE;
         end
         S_FILL: begin
            src_we    = pend_ff && (label_type'(lbl_rdata) == LBL_REPLACE);
            src_waddr = paddr_ff;
            src_wdata = remove_white_ff ? FILL_WHITE : FILL_BLACK;
            if (idx_ff < total_ff) begin
               idx_in   = idx_ff + TW'(1);
               pend_in  = 1'b1;
               paddr_in = idx_ff[AW-1:0];
            end else begin
               pend_in       = 1'b0;
               phase_in      = PH_READING;
               read_cnt_in   = '0;
               used_total_in = total_ff;
            end
         end
         default: begin
            phase_in = PH_LOADING;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         area_limit_ff   <= AREA_LIMIT_RST;
         remove_white_ff <= 1'b1;
         eight_ff        <= 1'b1;
         cols_ff         <= DIM_RST;
         rows_ff         <= DIM_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_AREA_LIMIT:      area_limit_ff   <= csr_wdata;
            REG_REMOVE_WHITE:    remove_white_ff <= csr_wdata[0];
            REG_EIGHT_CONNECTED: eight_ff        <= csr_wdata[0];
            REG_IMAGE_COLS:      cols_ff         <= csr_wdata[8:0];
            REG_IMAGE_ROWS:      rows_ff         <= csr_wdata[8:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         phase_ff      <= PH_LOADING;
         load_cnt_ff   <= '0;
         read_cnt_ff   <= '0;
         used_total_ff <= TW'(1);
         head_ff       <= '0;
         tail_ff       <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         load_cnt_ff   <= load_cnt_in;
         read_cnt_ff   <= read_cnt_in;
         used_total_ff <= used_total_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      total_ff    <= total_in;
      w_ff        <= w_in;
      h_ff        <= h_in;
      idx_ff      <= idx_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      nb_ff       <= nb_in;
      paddr_ff    <= paddr_in;
      naddr_ff    <= naddr_in;
      ncoord_ff   <= ncoord_in;
      rd_last_ff  <= rd_last_in;
      rsp_pix_ff  <= rsp_pix_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pix_ff;
   assign rsp_tlast  = rsp_last_ff;

   // a new result only ever comes out of the source memory read slot
   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_READ))
      else $error("result appeared without a read request");

   // queue pointers stay ordered while a region grows
   a_queue_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_GROW_POP || state_ff == S_NB_RD || state_ff == S_NB_CHK)
         |-> (head_ff <= tail_ff) && (tail_ff <= total_ff))
      else $error("grow queue pointers out of order");

   // requests are held off while the classify sweep runs
   a_busy_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLASS) |=> !req_tready || (state_ff == S_IDLE))
      else $error("request taken during processing");

endmodule

/* rtl/core/srr_ram.sv */
// ----------------------------------------------------------------------------
// srr_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module srr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/srr_addr.sv */
// ----------------------------------------------------------------------------
// srr_addr
// Neighbor coordinate, bounds check and linear address for the grow engine.
// ----------------------------------------------------------------------------
module srr_addr import srr_pkg::*; #(
   parameter int XW = 8,
   parameter int YW = 8,
   parameter int CW = 9,
   parameter int RW = 9,
   parameter int AW = 16
) (
   input  logic [XW-1:0] x,
   input  logic [YW-1:0] y,
   input  logic [2:0]    nb,
   input  logic          center,
   input  logic [CW-1:0] width,
   input  logic [RW-1:0] height,
   output logic          valid,
   output logic [XW-1:0] nx,
   output logic [YW-1:0] ny,
   output logic [AW-1:0] idx
);

   logic signed [1:0]    dx;
   logic signed [1:0]    dy;
   logic signed [XW+1:0] nx_s;
   logic signed [YW+1:0] ny_s;
   logic [YW+CW-1:0]     row_base;
   logic [YW+CW:0]       idx_sum;

   always_comb begin
      dx = center ? 2'sd0 : NB_DX[nb];
      dy = center ? 2'sd0 : NB_DY[nb];
      nx_s = $signed({2'b00, x}) + $signed({{XW{dx[1]}}, dx});
      ny_s = $signed({2'b00, y}) + $signed({{YW{dy[1]}}, dy});
      valid = (nx_s >= 0) && (ny_s >= 0)
         && (nx_s < $signed((XW+2)'(width)))
         && (ny_s < $signed((YW+2)'(height)));
      nx = nx_s[XW-1:0];
      ny = ny_s[YW-1:0];
      row_base = ny * width;
      idx_sum = (YW+CW+1)'(row_base) + (YW+CW+1)'(nx);
      idx = idx_sum[AW-1:0];
   end

endmodule
